// ===== src/dlw_pkg.sv =====
`timescale 1ns / 1ps

package dlw_pkg;

	// Character codes and limits
	localparam logic [7:0] CharCr   = 8'h0D;
	localparam logic [7:0] CharLf   = 8'h0A;
	localparam logic [7:0] HighByte = 8'h7F;
	localparam logic [9:0] MinCols  = 10'd2;
	localparam logic [9:0] ResetCols = 10'd40;

	// Result queue
	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	// Register map: index taken from paddr[2]
	localparam logic RegMaxColumns = 1'b0;

	// One display line result
	typedef struct packed {
		logic [10:0] line_length;
		logic [15:0] line_index;
		logic        last_line;
	} res_t;

	// Results produced for one item, handed to the queue
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic res_t mk_res(input logic [10:0] len, input logic [15:0] idx,
			input logic last);
		res_t r;
		r.line_length = len;
		r.line_index  = idx;
		r.last_line   = last;
		return r;
	endfunction

	// Line number after a line: back to zero after the last one, else saturating count
	function automatic logic [15:0] next_index(input logic [15:0] idx, input logic last);
		logic [15:0] r;
		if (last) begin
			r = '0;
		end else if (idx == 16'hFFFF) begin
			r = idx;
		end else begin
			r = idx + 16'd1;
		end
		return r;
	endfunction

endpackage

// ===== src/dlw_cfg.sv =====
`timescale 1ns / 1ps

module dlw_cfg
	import dlw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [9:0]  max_columns
);

	logic [9:0] max_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == RegMaxColumns);

	// Column limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= ResetCols;
		end else if (wr_en) begin
			max_q <= pwdata[9:0];
		end
	end

	// Read back; low address bits are ignored
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			RegMaxColumns: prdata = {22'd0, max_q};
			default:       prdata = '0;
		endcase
	end

	assign max_columns = max_q;

endmodule

// ===== src/dlw_core.sv =====
`timescale 1ns / 1ps

module dlw_core
	import dlw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	input  logic [9:0] max_columns,
	input  logic       space,
	output push_t      push
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eot_s1;
	logic        proc;
	logic        in_acc;

	logic [10:0] col_q;
	logic        odd_q;
	logic        pcr_q;
	logic [15:0] lc_q;

	logic [10:0] cc;
	logic        odd;
	logic        pcr;
	logic [15:0] lc;
	logic        fin;
	logic [1:0]  n;
	logic [10:0] lim;
	res_t        r0;
	res_t        r1;
	res_t        rn;

	// Item is worked on when the queue has room for two lines
	assign proc     = valid_s1 && space;
	assign in_stall = valid_s1 && !space;
	assign in_acc   = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc || (valid_s1 && !proc);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	// Line break decision for one byte
	always_comb begin
		lim = (max_columns < MinCols) ? {1'b0, MinCols} : {1'b0, max_columns};
		cc  = col_q;
		odd = odd_q;
		pcr = pcr_q;
		lc  = lc_q;
		fin = 1'b0;
		n   = 2'd0;
		r0  = '0;
		r1  = '0;
		rn  = '0;

		// held CR: LF joins it, anything else makes it ordinary
		if (pcr) begin
			pcr = 1'b0;
			if (byte_s1 == CharLf) begin
				r0  = mk_res(cc + 11'd1, lc, eot_s1);
				n   = 2'd1;
				lc  = next_index(lc, eot_s1);
				cc  = '0;
				odd = 1'b0;
				fin = 1'b1;
			end else if (cc >= lim) begin
				r0  = mk_res(cc, lc, 1'b0);
				n   = 2'd1;
				lc  = next_index(lc, 1'b0);
				cc  = '0;
				odd = 1'b0;
			end
		end

		if (!fin) begin
			if (byte_s1 == CharLf) begin
				rn = mk_res(cc + 11'd1, lc, eot_s1);
				if (n == 2'd0) r0 = rn; else r1 = rn;
				n   = n + 2'd1;
				lc  = next_index(lc, eot_s1);
				cc  = '0;
				odd = 1'b0;
			end else if ((byte_s1 == CharCr) && !eot_s1) begin
				cc  = cc + 11'd1;
				odd = 1'b0;
				pcr = 1'b1;
			end else begin
				cc  = cc + 11'd1;
				odd = (byte_s1 >= HighByte) ? !odd : 1'b0;
				if (cc >= lim) begin
					if (odd) begin
						// lead byte of a split double-byte char goes to the next line
						rn = mk_res(cc - 11'd1, lc, 1'b0);
						if (n == 2'd0) r0 = rn; else r1 = rn;
						n   = n + 2'd1;
						lc  = next_index(lc, 1'b0);
						cc  = 11'd1;
						odd = 1'b1;
						if (eot_s1) begin
							rn = mk_res(11'd1, lc, 1'b1);
							if (n == 2'd0) r0 = rn; else r1 = rn;
							n   = n + 2'd1;
							lc  = next_index(lc, 1'b1);
							cc  = '0;
							odd = 1'b0;
						end
					end else begin
						rn = mk_res(cc, lc, eot_s1);
						if (n == 2'd0) r0 = rn; else r1 = rn;
						n   = n + 2'd1;
						lc  = next_index(lc, eot_s1);
						cc  = '0;
						odd = 1'b0;
					end
				end else if (eot_s1) begin
					rn = mk_res(cc, lc, 1'b1);
					if (n == 2'd0) r0 = rn; else r1 = rn;
					n   = n + 2'd1;
					lc  = next_index(lc, 1'b1);
					cc  = '0;
					odd = 1'b0;
				end
			end
		end
	end

	// Line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			odd_q <= 1'b0;
			pcr_q <= 1'b0;
			lc_q  <= '0;
		end else if (proc) begin
			col_q <= cc;
			odd_q <= odd;
			pcr_q <= pcr;
			lc_q  <= lc;
		end
	end

	assign push.n  = proc ? n : 2'd0;
	assign push.r0 = r0;
	assign push.r1 = r1;

	// Two lines from one byte only when the second closes the text
	a_two_last: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && (n == 2'd2)) |-> r1.last_line)
		else $error("two lines without a final line");

	// A held CR always sits on a line
	a_cr_col: assert property (@(posedge clk) disable iff (!arst_n)
		pcr_q |-> (col_q != 11'd0))
		else $error("held CR on empty line");

	// After the final line the state is back at its start
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && (((n == 2'd1) && r0.last_line) || ((n == 2'd2) && r1.last_line)))
		|=> ((col_q == 11'd0) && (lc_q == 16'd0) && !pcr_q && !odd_q))
		else $error("state not cleared after final line");

endmodule

// ===== src/dlw_queue.sv =====
`timescale 1ns / 1ps

module dlw_queue
	import dlw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       push,
	output logic        space,
	output logic        out_valid,
	input  logic        out_stall,
	output res_t        head
);

	res_t                 mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_q;
	logic [QueuePtrW-1:0] rd_q;
	logic [QueueCntW-1:0] cnt_q;
	logic                 pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign space     = (cnt_q <= QueueCntW'(QueueDepth - 2));
	assign head      = mem_q[rd_q];

	// Storage: up to two lines written per cycle
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_q + QueuePtrW'(1)] <= push.r1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QueuePtrW'(push.n);
			rd_q  <= rd_q + QueuePtrW'(pop);
			cnt_q <= cnt_q + QueueCntW'(push.n) - QueueCntW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> (cnt_q <= QueueCntW'(QueueDepth - 2)))
		else $error("line queue overflow");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QueueCntW'(QueueDepth))
		else $error("line queue count out of range");

endmodule

// ===== src/dbcs_line_wrap_splitter.sv =====
`timescale 1ns / 1ps

// Line wrap splitter for mixed single/double-byte text. Takes one text byte per
// cycle and gives the byte length, number and last-line flag of each display
// line; the limit is max_columns bytes (register at address 0, reset 40, values
// below 2 act as 2). A new byte is accepted every cycle while the four-entry line
// queue has room for two lines; a byte that closes two lines at once (a moved
// double-byte lead at the end of the text, or a full line with a held CR just
// before the final byte) puts both into the queue at once, and the output drains
// one line a cycle unless stalled. Bytes are registered, their lines queued.
module dbcs_line_wrap_splitter
	import dlw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] line_length,
	output logic [15:0] line_index,
	output logic        last_line
);

	logic [9:0] max_columns;
	logic       space;
	push_t      push;
	res_t       head;

	dlw_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.max_columns (max_columns)
	);

	dlw_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.max_columns (max_columns),
		.space       (space),
		.push        (push)
	);

	dlw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space     (space),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign line_length = head.line_length;
	assign line_index  = head.line_index;
	assign last_line   = head.last_line;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import dlw_pkg::*;

	localparam logic [2:0] MaxColsAddr = {RegMaxColumns, 2'b00};
	localparam int QuietLimit = 5000;
	localparam int DrainCycles = 6;
	localparam int RandomItems = 540;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  text_byte = '0;
	logic        end_of_text = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [10:0] line_length;
	logic [15:0] line_index;
	logic        last_line;

	dbcs_line_wrap_splitter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.line_length (line_length),
		.line_index  (line_index),
		.last_line   (last_line)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Line splitter prediction state
	logic [9:0]  wrap_cols = ResetCols;
	logic [10:0] line_fill = '0;
	logic        high_odd = 1'b0;
	logic        cr_held = 1'b0;
	logic [15:0] line_no = '0;
	res_t        expected_lines[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int bytes_sent = 0;
	int lines_checked = 0;
	int col_settings = 0;
	int err_cnt = 0;
	int quiet_cycles = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		if (err_cnt < 20)
			$display("MISMATCH %s: got %0d, expected %0d (line %0d checked)",
				what, got, want, lines_checked);
		err_cnt++;
	endtask

	// Close the current line: queue the expected result and clear line state
	task automatic close_line(input logic [10:0] len, input logic last);
		res_t r;
		r.line_length = len;
		r.line_index  = line_no;
		r.last_line   = last;
		expected_lines.push_back(r);
		line_fill = '0;
		high_odd  = 1'b0;
		cr_held   = 1'b0;
		if (last)
			line_no = '0;
		else if (line_no != 16'hFFFF)
			line_no = line_no + 16'd1;
	endtask

	// Predict the lines ended by one accepted text byte
	task automatic predict_wrap(input logic [7:0] b, input logic eot);
		logic [10:0] lim;
		lim = (wrap_cols < MinCols) ? 11'(MinCols) : 11'(wrap_cols);
		if (cr_held) begin
			if (b == CharLf) begin
				close_line(line_fill + 11'd1, eot);
				return;
			end
			// held CR turns out to be an ordinary byte
			cr_held = 1'b0;
			if (line_fill >= lim)
				close_line(line_fill, 1'b0);
		end
		if (b == CharLf) begin
			close_line(line_fill + 11'd1, eot);
			return;
		end
		if (b == CharCr && !eot) begin
			line_fill = line_fill + 11'd1;
			high_odd  = 1'b0;
			cr_held   = 1'b1;
			return;
		end
		line_fill = line_fill + 11'd1;
		high_odd  = (b >= HighByte) ? ~high_odd : 1'b0;
		if (line_fill >= lim) begin
			if (high_odd) begin
				// double-byte lead moves on to the next line
				close_line(line_fill - 11'd1, 1'b0);
				line_fill = 11'd1;
				high_odd  = 1'b1;
				if (eot)
					close_line(11'd1, 1'b1);
			end else begin
				close_line(line_fill, eot);
			end
		end else if (eot) begin
			close_line(line_fill, 1'b1);
		end
	endtask

	// Send one item, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic eot);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid    <= 1'b1;
		text_byte   <= b;
		end_of_text <= eot;
		do @(posedge clk); while (in_stall);
		predict_wrap(b, eot);
		bytes_sent++;
	endtask

	// Stop sending and let every expected line come out
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_lines.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic check_max_columns(input logic [9:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= MaxColsAddr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[9:0] !== want)
			report_mismatch("max_columns readback", int'(prdata[9:0]), int'(want));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Register write, only with the splitter idle
	task automatic set_max_columns(input logic [9:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MaxColsAddr;
		pwdata  <= {22'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		wrap_cols = v;
		col_settings++;
		@(posedge clk);
		check_max_columns(v);
		@(posedge clk);
	endtask

	task automatic send_text(input logic [7:0] bytes[$]);
		int i;
		for (i = 0; i < bytes.size(); i++)
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	// Random text byte: mostly single-byte and double-byte halves, some terminators
	function automatic logic [7:0] random_text_byte();
		int r;
		r = $urandom_range(99);
		if (r < 6)
			return CharLf;
		else if (r < 12)
			return CharCr;
		else if (r < 50)
			return 8'($urandom_range(8'h7F, 8'hFF));
		else
			return 8'($urandom_range(0, 8'h7E));
	endfunction

	function automatic logic [9:0] random_cols();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return 10'($urandom_range(0, 1));
		else if (r < 15)
			return MinCols;
		else if (r < 20)
			return 10'($urandom_range(100, 1023));
		else if (r < 60)
			return 10'($urandom_range(3, 12));
		else
			return 10'($urandom_range(13, 72));
	endfunction

	// Reset value of the register and a short line at that width
	task automatic test_register_reset();
		check_max_columns(ResetCols);
		@(posedge clk);
		send_text('{8'h41, 8'h42});
		settle();
	endtask

	// Byte value extremes, an even and an odd high run at a natural wrap
	task automatic test_byte_extremes();
		set_max_columns(10'd4);
		send_text('{8'h00, 8'h7E, HighByte, 8'hFF, 8'h41, 8'h42, 8'hFE});
		send_text('{8'h41, 8'h42, 8'h43, 8'h80, CharLf});
		settle();
	endtask

	// CR at the limit joined by LF, CR as final byte, lone CR, empty line
	task automatic test_cr_handling();
		set_max_columns(10'd3);
		send_byte(8'h41, 1'b0);
		send_byte(8'h42, 1'b0);
		send_byte(CharCr, 1'b0);
		send_byte(CharLf, 1'b0);
		send_byte(CharCr, 1'b1);
		// held CR fills the line, then an ordinary byte
		send_text('{8'h41, 8'h42, CharCr, 8'h58, 8'h59});
		send_text('{8'h41, CharCr, 8'h42});
		send_byte(CharLf, 1'b1);
		settle();
	endtask

	// Line fills on the final byte with a moved lead: two lines from one byte
	task automatic test_final_fill();
		set_max_columns(10'd3);
		send_text('{8'h41, 8'h42, 8'h90});
		settle();
	endtask

	// Limit values below two act as two
	task automatic test_tiny_limit();
		set_max_columns(10'd0);
		send_text('{8'h41, 8'h42, 8'h43});
		settle();
		set_max_columns(10'd1);
		send_text('{8'h41, 8'h80, 8'h81, 8'h82});
		settle();
	endtask

	// Lowering the limit under a partly filled line
	task automatic test_limit_lowered();
		int i;
		set_max_columns(10'd10);
		for (i = 0; i < 6; i++)
			send_byte(8'h61 + 8'(i), 1'b0);
		settle();
		set_max_columns(10'd3);
		send_text('{8'h70, 8'h71});
		settle();
	endtask

	// Widest limit: a long line ended by CR LF stays whole
	task automatic test_widest_line();
		int i;
		set_max_columns(10'd1023);
		for (i = 0; i < 120; i++)
			send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
		send_byte(CharCr, 1'b0);
		send_byte(CharLf, 1'b1);
		settle();
	endtask

	// Random texts in phases, each at a fresh line width
	task automatic run_random_texts(input int target);
		int phase_items;
		int len;
		int i;
		while (bytes_sent < target) begin
			set_max_columns(random_cols());
			phase_items = 0;
			while (phase_items < 90) begin
				if ($urandom_range(99) < 85) begin
					len = $urandom_range(1, 60);
					for (i = 0; i < len; i++)
						send_byte(random_text_byte(), i == len - 1);
				end else begin
					// raw bytes with the end mark anywhere
					len = $urandom_range(1, 10);
					for (i = 0; i < len; i++)
						send_byte(8'($urandom), $urandom_range(19) == 0);
				end
				phase_items += len;
			end
			settle();
		end
	endtask

	// Receiver stalls at random
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	// Compare each line taken from the output with the oldest expectation
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_lines.size() == 0) begin
				report_mismatch("unexpected line, length", int'(line_length), 0);
			end else begin
				want = expected_lines.pop_front();
				if (line_length !== want.line_length)
					report_mismatch("line_length", int'(line_length),
						int'(want.line_length));
				if (line_index !== want.line_index)
					report_mismatch("line_index", int'(line_index), int'(want.line_index));
				if (last_line !== want.last_line)
					report_mismatch("last_line", int'(last_line), int'(want.last_line));
			end
			lines_checked++;
		end
	end

	// Watchdog on cycles with no item moving either way
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("Timeout: no progress for %0d cycles", QuietLimit);
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		send_idle_pct = 15;
		recv_idle_pct = 61;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_reset();
		test_byte_extremes();
		test_cr_handling();
		test_final_fill();
		test_tiny_limit();
		test_limit_lowered();
		test_widest_line();

		run_random_texts(bytes_sent + RandomItems / 3);
		send_idle_pct = 61;
		recv_idle_pct = 15;
		run_random_texts(bytes_sent + RandomItems / 3);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_texts(bytes_sent + RandomItems / 3);

		$display("Sent %0d text bytes and checked %0d display lines", bytes_sent,
			lines_checked);
		$display("Line widths written: %0d, from 0 to 1023, under three idling patterns",
			col_settings);
		if (err_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
